[rtl/trbia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbia_pkg
// Shared constants and control types for the two-region ID allocator.
// ----------------------------------------------------------------------------
package trbia_pkg;

    localparam int REGION_SIZE      = 1024;
    localparam int INDEX_W          = 11;
    localparam int WORD_W           = 32;
    localparam int POS_W            = $clog2(WORD_W);
    localparam int MAP_DEPTH        = 2 * REGION_SIZE;
    localparam int NUM_WORDS        = MAP_DEPTH / WORD_W;
    localparam int ADDR_W           = $clog2(NUM_WORDS);
    localparam int WORDS_PER_REGION = REGION_SIZE / WORD_W;
    localparam int SCAN_W           = $clog2(WORDS_PER_REGION) + 1;

    localparam logic [1:0] FUNC_FIND    = 2'd0;
    localparam logic [1:0] FUNC_CLAIM   = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    typedef struct packed {
        logic capture;   // latch request fields, reset scan counter
        logic scan_rd;   // issue next region word read
        logic rmw_rd;    // read word holding entry_index
        logic rmw_wr;    // update word, load claim/release result
        logic res_find;  // load find result from current read data
        logic res_fail;  // load zero result
        logic out_load;  // move result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       hit;       // read word has a free bit
        logic       scan_end;  // read word is the last of the region
    } dp_status_t;

endpackage

[rtl/trbia_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbia_dp
// Datapath: request registers, bitmap memory with row valid bits, scan
// counter, priority encoder, read-modify-write logic and result registers.
// ----------------------------------------------------------------------------
module trbia_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  trbia_pkg::dp_cmd_t             cmd,
    input  logic [1:0]                     s_func,
    input  logic                           s_region,
    input  logic [trbia_pkg::INDEX_W-1:0]  s_entry_index,
    output trbia_pkg::dp_status_t          status,
    output logic [trbia_pkg::INDEX_W-1:0]  m_result_index,
    output logic                           m_success
);
    import trbia_pkg::*;

    logic [1:0]         func_reg;
    logic               region_reg;
    logic [INDEX_W-1:0] idx_reg;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] row_valid_reg;

    logic [SCAN_W-1:0]  iss_cnt_reg;
    logic               rd_pend_reg;
    logic [ADDR_W-1:0]  rd_word_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_row_valid_reg;

    logic [INDEX_W-1:0] res_index_reg;
    logic               res_ok_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_ok_reg;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  eff_word;
    logic [POS_W-1:0]   free_pos;
    logic [POS_W-1:0]   bit_pos;
    logic [WORD_W-1:0]  bit_mask;
    logic               in_rgn;
    logic               rmw_ok;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;

    // lowest clear bit of a word
    function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[INDEX_W-1:POS_W];
        if (cmd.scan_rd && !iss_cnt_reg[SCAN_W-1]) begin
            rd_en   = 1'b1;
            rd_addr = {region_reg, iss_cnt_reg[SCAN_W-2:0]};
        end else if (cmd.rmw_rd) begin
            rd_en   = 1'b1;
        end
    end

    // rows never written read as all free
    assign eff_word = rd_row_valid_reg ? rd_data_reg : '0;
    assign free_pos = lowest_zero(eff_word);
    assign bit_pos  = idx_reg[POS_W-1:0];
    assign bit_mask = WORD_W'(1) << bit_pos;
    assign in_rgn   = (idx_reg[INDEX_W-1] == region_reg);
    assign rmw_ok   = (func_reg == FUNC_CLAIM) ? (in_rgn && !eff_word[bit_pos]) : in_rgn;
    assign wr_en    = cmd.rmw_wr && rmw_ok;
    assign wr_addr  = idx_reg[INDEX_W-1:POS_W];
    assign wr_data  = (func_reg == FUNC_CLAIM) ? (eff_word | bit_mask)
                                               : (eff_word & ~bit_mask);

    assign status.func     = func_reg;
    assign status.hit      = rd_pend_reg && !(&eff_word);
    assign status.scan_end = rd_pend_reg && (&rd_word_reg[SCAN_W-2:0]);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg      <= mem[rd_addr];
            rd_row_valid_reg <= row_valid_reg[rd_addr];
            rd_word_reg      <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_pend_reg   <= 1'b0;
            iss_cnt_reg   <= '0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_pend_reg <= rd_en;
            if (cmd.capture) begin
                iss_cnt_reg <= '0;
            end else if (rd_en && cmd.scan_rd) begin
                iss_cnt_reg <= iss_cnt_reg + SCAN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg   <= s_func;
            region_reg <= s_region;
            idx_reg    <= s_entry_index;
        end
        if (cmd.res_find) begin
            res_index_reg <= status.hit ? {rd_word_reg, free_pos} : '0;
            res_ok_reg    <= status.hit;
        end else if (cmd.rmw_wr) begin
            res_index_reg <= '0;
            res_ok_reg    <= rmw_ok;
        end else if (cmd.res_fail) begin
            res_index_reg <= '0;
            res_ok_reg    <= 1'b0;
        end
        if (cmd.out_load) begin
            out_index_reg <= res_index_reg;
            out_ok_reg    <= res_ok_reg;
        end
    end

    assign m_result_index = out_index_reg;
    assign m_success      = out_ok_reg;

endmodule

[rtl/trbia_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbia_ctrl
// Controller: request sequencing state machine and output valid flag.
// ----------------------------------------------------------------------------
module trbia_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  trbia_pkg::dp_status_t  status,
    output trbia_pkg::dp_cmd_t     cmd
);
    import trbia_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_SCAN     = 6'b000100,
        ST_RMW_RD   = 6'b001000,
        ST_RMW_WR   = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (status.func == FUNC_FIND) begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN;
                end else if (status.func == FUNC_CLAIM || status.func == FUNC_RELEASE) begin
                    cmd.rmw_rd  = 1'b1;
                    state_next  = ST_RMW_RD;
                end else begin
                    cmd.res_fail = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.hit || status.scan_end) begin
                    cmd.res_find = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_RMW_RD: begin
                // read issued in dispatch; data is already registered here
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                cmd.rmw_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/two_region_bitmap_id_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_region_bitmap_id_allocator
// Used/free bitmap of 2048 IDs in a low and a high region of 1024 each.
// ----------------------------------------------------------------------------
// One request is handled at a time. Find scans the chosen region's 32 bitmap
// words through the bitmap memory, one word per cycle with a priority
// encoder on the registered read data. Claim and release do a
// read-modify-write of one word; an unused func code loads a failed result.
// A request also holds the block for any wait for the output register. The
// result sits in an output register, so the next request is taken while it
// waits for m_ready. The bitmap is all free right after reset: each memory
// row has a valid bit cleared by reset, so no clearing pass is needed.
module two_region_bitmap_id_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic                           s_region,
    input  logic [trbia_pkg::INDEX_W-1:0]  s_entry_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [trbia_pkg::INDEX_W-1:0]  m_result_index,
    output logic                           m_success
);
    import trbia_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    trbia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    trbia_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_func         (s_func),
        .s_region       (s_region),
        .s_entry_index  (s_entry_index),
        .status         (status),
        .m_result_index (m_result_index),
        .m_success      (m_success)
    );

endmodule
